/* rtl/hsd_pkg.sv */
// Shared types, codes and threshold arithmetic for the headset jack and button detector.
// No dependencies; every other file of the block refers to this package by scoped names.
package hsd_pkg;

    localparam int AdcBits = 12;
    localparam int MvBits = 11;
    localparam int CodeBits = 8;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits = 11;

    localparam int MvFullScale = 1400;
    // Reciprocal of 175 scaled by 2^24, rounded up; exact for every value in use.
    localparam int RecipMul = 95870;
    localparam int RecipShift = 19;
    localparam int RecipBits = 28;

    localparam logic [1:0] OP_JACK = 2'd0;
    localparam logic [1:0] OP_HOOK = 2'd1;
    localparam logic [1:0] OP_TIMER = 2'd2;

    localparam logic [1:0] JACK_REMOVED = 2'd0;
    localparam logic [1:0] JACK_HEADSET = 2'd1;
    localparam logic [1:0] JACK_HEADPHONE = 2'd2;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_HOOK = 2'd1;
    localparam logic [1:0] BTN_VOL_UP = 2'd2;
    localparam logic [1:0] BTN_VOL_DOWN = 2'd3;

    localparam logic [2:0] REG_HOOK_PRESS = 3'd0;
    localparam logic [2:0] REG_VOL_UP_PRESS = 3'd1;
    localparam logic [2:0] REG_VOL_DOWN_PRESS = 3'd2;
    localparam logic [2:0] REG_MIC_DETECT = 3'd3;
    localparam logic [2:0] REG_PRESS_RELEASE = 3'd4;
    localparam logic [2:0] REG_DETECT_INVERT = 3'd5;

    localparam logic [CodeBits-1:0] CODE_NONE = 8'hFF;

    typedef struct packed {
        logic [1:0]         op;
        logic               jack_level;
        logic [AdcBits-1:0] adc_code;
    } item_t;

    typedef struct packed {
        logic [1:0]          jack_state;
        logic                mic_bias_on;
        logic                hook_irq_on;
        logic                key_event;
        logic [1:0]          key_code;
        logic                key_pressed;
        logic                rejected;
        logic                threshold_write;
        logic [CodeBits-1:0] low_threshold;
        logic [CodeBits-1:0] high_threshold;
        logic [1:0]          button_state;
    } result_t;

    typedef struct packed {
        logic [MvBits-1:0] hook_press_mv;
        logic [MvBits-1:0] vol_up_press_mv;
        logic [MvBits-1:0] vol_down_press_mv;
        logic [MvBits-1:0] mic_detect_mv;
        logic [MvBits-1:0] press_release_mv;
        logic              detect_invert;
    } cfg_t;

    typedef struct packed {
        logic [1:0] jack_now;
        logic [1:0] held_button;
        logic       hook_enabled;
    } state_t;

    function automatic logic [CodeBits-1:0] mv_to_code(logic [MvBits-1:0] mv);
        logic [RecipBits-1:0] prod;
        prod = RecipBits'(mv) * RecipBits'(RecipMul);
        if (mv >= MvBits'(MvFullScale))
            return CODE_NONE;
        return prod[RecipShift+CodeBits-1:RecipShift];
    endfunction

    function automatic logic [CodeBits-1:0] low_code(logic [MvBits-1:0] mv);
        return (mv == '0) ? '0 : mv_to_code(mv);
    endfunction

    function automatic logic [CodeBits-1:0] high_code(logic [MvBits-1:0] mv);
        return (mv == '0) ? CODE_NONE : mv_to_code(mv);
    endfunction

endpackage

/* rtl/hsd_item_if.sv */
// Valid/ready channel carrying one detector event per beat.
// Depends on hsd_pkg for the payload type.
interface hsd_item_if;
    logic          valid;
    logic          ready;
    hsd_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

/* rtl/hsd_result_if.sv */
// Valid/ready channel carrying one detector result per beat.
// Depends on hsd_pkg for the payload type.
interface hsd_result_if;
    logic            valid;
    logic            ready;
    hsd_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

/* rtl/hsd_step.sv */
// Combinational event decoder: next jack and button state and the result of one event.
// Depends on hsd_pkg for types, codes and the threshold conversion.
module hsd_step (
    input  hsd_pkg::item_t   item,
    input  hsd_pkg::state_t  state,
    input  hsd_pkg::cfg_t    cfg,
    output hsd_pkg::state_t  state_next,
    output hsd_pkg::result_t res
);

    logic [hsd_pkg::AdcBits+hsd_pkg::MvBits-1:0] prod;
    logic [hsd_pkg::MvBits-1:0]                  mv;
    logic                                        present;
    logic                                        judge;
    logic [1:0]                                  btn;
    logic [hsd_pkg::CodeBits-1:0]                rel_lo;
    logic [hsd_pkg::CodeBits-1:0]                rel_hi;

    assign prod = (hsd_pkg::AdcBits + hsd_pkg::MvBits)'(item.adc_code)
                * (hsd_pkg::AdcBits + hsd_pkg::MvBits)'(hsd_pkg::MvFullScale);
    assign mv = prod[hsd_pkg::AdcBits+hsd_pkg::MvBits-1:hsd_pkg::AdcBits];
    assign present = item.jack_level ^ cfg.detect_invert;
    assign rel_lo = hsd_pkg::low_code(cfg.press_release_mv);
    assign rel_hi = hsd_pkg::high_code(cfg.press_release_mv);

    always_comb
    begin
        state_next = state;
        res = '0;
        judge = 1'b0;
        btn = hsd_pkg::BTN_NONE;

        case (item.op)
            hsd_pkg::OP_JACK:
            begin
                state_next.hook_enabled = 1'b0;
                if (present)
                begin
                    if (mv < cfg.mic_detect_mv)
                    begin
                        state_next.jack_now = hsd_pkg::JACK_HEADPHONE;
                    end
                    else
                    begin
                        state_next.jack_now = hsd_pkg::JACK_HEADSET;
                        state_next.hook_enabled = 1'b1;
                        res.threshold_write = 1'b1;
                        res.low_threshold = rel_lo;
                        res.high_threshold = hsd_pkg::CODE_NONE;
                    end
                end
                else
                begin
                    state_next.jack_now = hsd_pkg::JACK_REMOVED;
                    state_next.held_button = hsd_pkg::BTN_NONE;
                end
            end
            hsd_pkg::OP_HOOK:
            begin
                if (state.hook_enabled)
                begin
                    if (!present)
                        state_next.hook_enabled = 1'b0;
                    else
                        judge = 1'b1;
                end
            end
            hsd_pkg::OP_TIMER:
            begin
                judge = (state.held_button != hsd_pkg::BTN_NONE)
                     && (mv >= cfg.press_release_mv);
            end
            default:
            begin
                judge = 1'b0;
            end
        endcase

        if (judge)
        begin
            if (mv < cfg.press_release_mv)
            begin
                if (state.held_button == hsd_pkg::BTN_NONE)
                begin
                    if (mv < cfg.hook_press_mv)
                        btn = hsd_pkg::BTN_HOOK;
                    else if (mv < cfg.vol_up_press_mv)
                        btn = hsd_pkg::BTN_VOL_UP;
                    else if (mv < cfg.vol_down_press_mv)
                        btn = hsd_pkg::BTN_VOL_DOWN;
                end
                if (btn == hsd_pkg::BTN_NONE)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    state_next.held_button = btn;
                    res.key_event = 1'b1;
                    res.key_code = btn - 2'd1;
                    res.key_pressed = 1'b1;
                    res.threshold_write = 1'b1;
                    res.low_threshold = '0;
                    res.high_threshold = rel_hi;
                end
            end
            else if (state.held_button != hsd_pkg::BTN_NONE)
            begin
                res.key_event = 1'b1;
                res.key_code = state.held_button - 2'd1;
                res.key_pressed = 1'b0;
                state_next.held_button = hsd_pkg::BTN_NONE;
                res.threshold_write = 1'b1;
                res.low_threshold = rel_lo;
                res.high_threshold = hsd_pkg::CODE_NONE;
            end
            else
            begin
                res.rejected = 1'b1;
            end
        end

        res.jack_state = state_next.jack_now;
        res.mic_bias_on = (state_next.jack_now == hsd_pkg::JACK_HEADSET);
        res.hook_irq_on = state_next.hook_enabled;
        res.button_state = state_next.held_button;
    end

endmodule

/* rtl/headset_jack_and_button_detector.sv */
// Top level of the headset jack and button detector: input register, decoder, result register.
// Depends on hsd_pkg, hsd_item_if, hsd_result_if and hsd_step.
//
// The block takes one event per clock cycle while the result side is not stalled and returns
// exactly one result per event. An event waits in the input register, is decoded
// combinationally against the jack and button state and lands in the result register; the
// state is updated at the edge where the event moves on, so back-to-back events see each
// other's effects. A stalled result side holds one result while one more event is taken.
// Configuration writes take effect at the next edge.
module headset_jack_and_button_detector (
    input  logic                                   clk,
    input  logic                                   rst_n,
    hsd_item_if.sink                               item,
    hsd_result_if.source                           result,
    input  logic                                   cfg_we,
    input  logic [hsd_pkg::CfgIndexBits-1:0]       cfg_index,
    input  logic [hsd_pkg::CfgDataBits-1:0]        cfg_data
);

    logic             in_valid_reg;
    hsd_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    hsd_pkg::result_t out_res_reg;
    hsd_pkg::state_t  state_reg;
    hsd_pkg::state_t  state_next;
    hsd_pkg::cfg_t    cfg_reg;
    hsd_pkg::result_t res_next;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || result.ready;
    assign advance = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    assign result.valid = out_valid_reg;
    assign result.payload = out_res_reg;

    hsd_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.jack_now <= hsd_pkg::JACK_REMOVED;
            state_reg.held_button <= hsd_pkg::BTN_NONE;
            state_reg.hook_enabled <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= item.payload;
        if (advance)
            out_res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hook_press_mv <= 11'd20;
            cfg_reg.vol_up_press_mv <= 11'd60;
            cfg_reg.vol_down_press_mv <= 11'd110;
            cfg_reg.mic_detect_mv <= 11'd300;
            cfg_reg.press_release_mv <= 11'd300;
            cfg_reg.detect_invert <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsd_pkg::REG_HOOK_PRESS:     cfg_reg.hook_press_mv <= cfg_data;
                hsd_pkg::REG_VOL_UP_PRESS:   cfg_reg.vol_up_press_mv <= cfg_data;
                hsd_pkg::REG_VOL_DOWN_PRESS: cfg_reg.vol_down_press_mv <= cfg_data;
                hsd_pkg::REG_MIC_DETECT:     cfg_reg.mic_detect_mv <= cfg_data;
                hsd_pkg::REG_PRESS_RELEASE:  cfg_reg.press_release_mv <= cfg_data;
                hsd_pkg::REG_DETECT_INVERT:  cfg_reg.detect_invert <= cfg_data[0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

/* rtl/hsd_checker.sv */
// Port-level assertions for the headset jack and button detector, bound to the top level.
// Depends on hsd_pkg for the result type and codes; watches the result channel's signals.
module hsd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input hsd_pkg::result_t result_payload
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_payload))
        else $error("A stalled result beat changed or vanished.");

    a_mic_bias: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result_payload.mic_bias_on == (result_payload.jack_state == hsd_pkg::JACK_HEADSET))
        else $error("Mic bias does not follow the headset state.");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result_payload.key_event || (result_payload.key_code == 2'd0
                && !result_payload.key_pressed))
            && (result_payload.threshold_write || (result_payload.low_threshold == '0
                && result_payload.high_threshold == '0)))
        else $error("Key or threshold fields set without their flag.");

    a_removed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_payload.jack_state == hsd_pkg::JACK_REMOVED |->
            result_payload.button_state == hsd_pkg::BTN_NONE && !result_payload.hook_irq_on)
        else $error("A button or the hook interrupt is live with the jack removed.");

endmodule

bind headset_jack_and_button_detector hsd_checker u_hsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

/* tb/hsd_event_checker.sv */
`timescale 1ns / 1ps
// Checker for the headset jack and button detector: predicts the result of every accepted
// event beat and compares each result beat with the oldest one due.
// Depends on hsd_pkg and the two channel interfaces.
module hsd_event_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    hsd_item_if.monitor                       events,
    hsd_result_if.monitor                     results,
    input  logic                              cfg_we,
    input  logic [hsd_pkg::CfgIndexBits-1:0]  cfg_index,
    input  logic [hsd_pkg::CfgDataBits-1:0]   cfg_data,
    output int                                pending,
    output int                                fail_count,
    output int                                results_seen,
    output int                                key_reports,
    output int                                rejections
);
    import hsd_pkg::*;

    cfg_t    det_cfg;
    state_t  det_state;
    result_t outcomes_due[$];
    result_t due;
    int      fails;
    int      seen;
    int      keys;
    int      rejects;

    function automatic logic [CodeBits-1:0] window_code(int mv);
        int c;
        c = ((mv << 12) / MvFullScale) >> 4;
        if (c > 255)
            c = 255;
        return CodeBits'(c);
    endfunction

    function automatic logic [CodeBits-1:0] low_window(int mv);
        return (mv == 0) ? '0 : window_code(mv);
    endfunction

    function automatic logic [CodeBits-1:0] high_window(int mv);
        return (mv == 0) ? CODE_NONE : window_code(mv);
    endfunction

    function automatic result_t detect_outcome(item_t ev);
        result_t    r;
        logic       present;
        logic       judge;
        logic [1:0] pick;
        int         mv;
        int         release_mv;
        r = '0;
        judge = 1'b0;
        pick = BTN_NONE;
        present = ev.jack_level ^ det_cfg.detect_invert;
        mv = (int'(ev.adc_code) * MvFullScale) >> AdcBits;
        release_mv = int'(det_cfg.press_release_mv);
        case (ev.op)
            OP_JACK:
            begin
                det_state.hook_enabled = 1'b0;
                if (!present)
                begin
                    det_state.jack_now = JACK_REMOVED;
                    det_state.held_button = BTN_NONE;
                end
                else if (mv < int'(det_cfg.mic_detect_mv))
                    det_state.jack_now = JACK_HEADPHONE;
                else
                begin
                    det_state.jack_now = JACK_HEADSET;
                    det_state.hook_enabled = 1'b1;
                    r.threshold_write = 1'b1;
                    r.low_threshold = low_window(release_mv);
                    r.high_threshold = CODE_NONE;
                end
            end
            OP_HOOK:
            begin
                if (det_state.hook_enabled)
                begin
                    if (present)
                        judge = 1'b1;
                    else
                        det_state.hook_enabled = 1'b0;
                end
            end
            OP_TIMER:
                judge = (det_state.held_button != BTN_NONE) && (mv >= release_mv);
            default:
            begin
            end
        endcase
        if (judge && mv < release_mv)
        begin
            if (det_state.held_button == BTN_NONE)
            begin
                if (mv < int'(det_cfg.hook_press_mv))
                    pick = BTN_HOOK;
                else if (mv < int'(det_cfg.vol_up_press_mv))
                    pick = BTN_VOL_UP;
                else if (mv < int'(det_cfg.vol_down_press_mv))
                    pick = BTN_VOL_DOWN;
            end
            if (pick == BTN_NONE)
                r.rejected = 1'b1;
            else
            begin
                det_state.held_button = pick;
                r.key_event = 1'b1;
                r.key_code = pick - 2'd1;
                r.key_pressed = 1'b1;
                r.threshold_write = 1'b1;
                r.low_threshold = '0;
                r.high_threshold = high_window(release_mv);
            end
        end
        else if (judge && det_state.held_button != BTN_NONE)
        begin
            r.key_event = 1'b1;
            r.key_code = det_state.held_button - 2'd1;
            det_state.held_button = BTN_NONE;
            r.threshold_write = 1'b1;
            r.low_threshold = low_window(release_mv);
            r.high_threshold = CODE_NONE;
        end
        else if (judge)
            r.rejected = 1'b1;
        r.jack_state = det_state.jack_now;
        r.mic_bias_on = (det_state.jack_now == JACK_HEADSET);
        r.hook_irq_on = det_state.hook_enabled;
        r.button_state = det_state.held_button;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_outcome(input result_t want, input result_t got);
        report_field("jack_state", int'(want.jack_state), int'(got.jack_state));
        report_field("mic_bias_on", int'(want.mic_bias_on), int'(got.mic_bias_on));
        report_field("hook_irq_on", int'(want.hook_irq_on), int'(got.hook_irq_on));
        report_field("key_event", int'(want.key_event), int'(got.key_event));
        report_field("key_code", int'(want.key_code), int'(got.key_code));
        report_field("key_pressed", int'(want.key_pressed), int'(got.key_pressed));
        report_field("rejected", int'(want.rejected), int'(got.rejected));
        report_field("threshold_write", int'(want.threshold_write), int'(got.threshold_write));
        report_field("low_threshold", int'(want.low_threshold), int'(got.low_threshold));
        report_field("high_threshold", int'(want.high_threshold), int'(got.high_threshold));
        report_field("button_state", int'(want.button_state), int'(got.button_state));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_cfg.hook_press_mv = MvBits'(20);
            det_cfg.vol_up_press_mv = MvBits'(60);
            det_cfg.vol_down_press_mv = MvBits'(110);
            det_cfg.mic_detect_mv = MvBits'(300);
            det_cfg.press_release_mv = MvBits'(300);
            det_cfg.detect_invert = 1'b0;
            det_state.jack_now = JACK_REMOVED;
            det_state.held_button = BTN_NONE;
            det_state.hook_enabled = 1'b0;
            outcomes_due.delete();
            fails = 0;
            seen = 0;
            keys = 0;
            rejects = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                seen++;
                if (outcomes_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result beat with nothing due: expected none, got %h",
                             $time, results.payload);
                end
                else
                    compare_outcome(outcomes_due.pop_front(), results.payload);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOOK_PRESS:     det_cfg.hook_press_mv = cfg_data[MvBits-1:0];
                    REG_VOL_UP_PRESS:   det_cfg.vol_up_press_mv = cfg_data[MvBits-1:0];
                    REG_VOL_DOWN_PRESS: det_cfg.vol_down_press_mv = cfg_data[MvBits-1:0];
                    REG_MIC_DETECT:     det_cfg.mic_detect_mv = cfg_data[MvBits-1:0];
                    REG_PRESS_RELEASE:  det_cfg.press_release_mv = cfg_data[MvBits-1:0];
                    REG_DETECT_INVERT:  det_cfg.detect_invert = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (events.valid && events.ready)
            begin
                due = detect_outcome(events.payload);
                keys += int'(due.key_event);
                rejects += int'(due.rejected);
                outcomes_due.push_back(due);
            end
        end
        pending <= outcomes_due.size();
        fail_count <= fails;
        results_seen <= seen;
        key_reports <= keys;
        rejections <= rejects;
    end

endmodule

/* tb/tb_headset_jack_and_button_detector.sv */
`timescale 1ns / 1ps
// Top of the detector testbench: clock, reset, register settings and event stimulus with
// random idling on both channels, and the verdict.
// Depends on hsd_pkg, the channel interfaces, the detector and hsd_event_checker.
module tb_headset_jack_and_button_detector;
    import hsd_pkg::*;

    localparam logic [1:0] OpUnused = 2'd3;
    localparam int EventsPerSetting = 100;
    localparam int SettingCount = 8;
    localparam int HoldOffSetting = 4;
    localparam int PauseSetting = 5;
    localparam int SteadySetting = 3;
    localparam int HoldOffCycles = 300;
    localparam int QuietLimit = 4000;
    localparam int DrainCycles = 10;
    localparam int MaxMv = 1399;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_data;
    logic                    idle_on;
    int                      pending;
    int                      fail_count;
    int                      results_seen;
    int                      key_reports;
    int                      rejections;
    int                      events_sent;
    int                      settings_used;
    int                      stall_requests;
    int                      stall_served;
    int                      hold_left;
    int                      quiet;
    int                      p;
    int                      n;
    cfg_t                    cur_cfg;
    item_t                   opening[$];

    hsd_item_if event_ch ();
    hsd_result_if result_ch ();

    headset_jack_and_button_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (event_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hsd_event_checker outcome_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .events       (event_ch),
        .results      (result_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .key_reports  (key_reports),
        .rejections   (rejections)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int adc_for_mv(int mv);
        int m;
        m = (mv > MaxMv) ? MaxMv : mv;
        return (m * 4096 + MvFullScale - 1) / MvFullScale;
    endfunction

    function automatic int mv_between(int lo, int hi);
        if (lo > hi || lo > MaxMv)
            return int'($urandom_range(MaxMv));
        return int'($urandom_range((hi > MaxMv) ? MaxMv : hi, lo));
    endfunction

    function automatic item_t make_event(logic [1:0] op, logic level, int code);
        item_t ev;
        ev.op = op;
        ev.jack_level = level;
        ev.adc_code = AdcBits'(code);
        return ev;
    endfunction

    function automatic item_t random_event();
        item_t ev;
        logic  present;
        int    pick;
        int    band;
        int    mv;
        int    top;
        int    edges [5];
        present = ~cur_cfg.detect_invert;
        edges[0] = 0;
        edges[1] = int'(cur_cfg.hook_press_mv);
        edges[2] = int'(cur_cfg.vol_up_press_mv);
        edges[3] = int'(cur_cfg.vol_down_press_mv);
        edges[4] = int'(cur_cfg.press_release_mv);
        pick = int'($urandom_range(99));
        if (pick < 10)
        begin
            if ($urandom_range(9) < 7)
                mv = mv_between(int'(cur_cfg.mic_detect_mv), MaxMv);
            else
                mv = int'($urandom_range(MaxMv));
            ev = make_event(OP_JACK, ($urandom_range(9) < 8) ? present : ~present,
                            adc_for_mv(mv));
        end
        else if (pick < 55)
        begin
            if ($urandom_range(9) < 6)
            begin
                band = int'($urandom_range(3));
                top = (edges[band + 1] < edges[4]) ? edges[band + 1] : edges[4];
                mv = mv_between(edges[band], top - 1);
            end
            else
                mv = mv_between(edges[4], MaxMv);
            ev = make_event(OP_HOOK, ($urandom_range(19) != 0) ? present : ~present,
                            adc_for_mv(mv));
        end
        else if (pick < 78)
        begin
            if ($urandom_range(9) < 7)
                mv = mv_between(edges[4], MaxMv);
            else
                mv = int'($urandom_range(MaxMv));
            ev = make_event(OP_TIMER, $urandom_range(1) != 0, adc_for_mv(mv));
        end
        else if (pick < 82)
            ev = make_event(OpUnused, $urandom_range(1) != 0, int'($urandom_range(4095)));
        else
            ev = make_event(2'($urandom_range(3)), $urandom_range(1) != 0,
                            int'($urandom_range(4095)));
        return ev;
    endfunction

    function automatic cfg_t setting_for(int idx);
        cfg_t s;
        int   hook;
        int   up;
        int   down;
        int   rel;
        int   mic;
        logic inv;
        hook = 20;
        up = 60;
        down = 110;
        mic = 300;
        rel = 300;
        inv = $urandom_range(1) != 0;
        case (idx)
            0:
                inv = 1'b1;
            1:
            begin
                hook = 0;
                up = 0;
                down = 0;
                mic = 0;
                rel = 0;
                inv = 1'b0;
            end
            2:
            begin
                hook = MvFullScale;
                up = MvFullScale;
                down = MvFullScale;
                mic = MvFullScale;
                rel = MvFullScale;
                inv = 1'b1;
            end
            5:
            begin
                hook = int'($urandom_range(MvFullScale));
                up = int'($urandom_range(MvFullScale));
                down = int'($urandom_range(MvFullScale));
                mic = int'($urandom_range(MvFullScale));
                rel = int'($urandom_range(MvFullScale));
            end
            7:
                inv = 1'b0;
            default:
            begin
                hook = int'($urandom_range(300));
                up = hook + int'($urandom_range(200));
                down = up + int'($urandom_range(200));
                rel = down + int'($urandom_range(400));
                mic = int'($urandom_range(MvFullScale));
            end
        endcase
        s.hook_press_mv = MvBits'(hook);
        s.vol_up_press_mv = MvBits'(up);
        s.vol_down_press_mv = MvBits'(down);
        s.mic_detect_mv = MvBits'(mic);
        s.press_release_mv = MvBits'(rel);
        s.detect_invert = inv;
        return s;
    endfunction

    task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                             input logic [CfgDataBits-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_setting(input cfg_t s);
        write_reg(REG_HOOK_PRESS, s.hook_press_mv);
        write_reg(REG_VOL_UP_PRESS, s.vol_up_press_mv);
        write_reg(REG_VOL_DOWN_PRESS, s.vol_down_press_mv);
        write_reg(REG_MIC_DETECT, s.mic_detect_mv);
        write_reg(REG_PRESS_RELEASE, s.press_release_mv);
        write_reg(REG_DETECT_INVERT, CfgDataBits'(s.detect_invert));
        cfg_we <= 1'b0;
    endtask

    task automatic send_event(input item_t ev);
        if (idle_on && $urandom_range(99) < 27)
        begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 27)
                @(posedge clk);
        end
        event_ch.valid <= 1'b1;
        event_ch.payload <= ev;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic wait_drained();
        event_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver idles at random or stays ready, or holds off a long stretch when asked to.
    initial
    begin
        result_ch.ready = 1'b0;
        stall_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                hold_left = HoldOffCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on)
                result_ch.ready <= ($urandom_range(99) >= 27);
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if (!rst_n || (event_ch.valid && event_ch.ready)
                || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        event_ch.valid = 1'b0;
        event_ch.payload = '0;
        idle_on = 1'b1;
        stall_requests = 0;
        events_sent = 0;
        settings_used = 1;
        cur_cfg = setting_for(7);

        opening.push_back(make_event(OP_HOOK, 1'b1, 0));
        opening.push_back(make_event(OP_TIMER, 1'b1, 4095));
        opening.push_back(make_event(OpUnused, 1'b1, 4095));
        opening.push_back(make_event(OP_JACK, 1'b1, 0));
        opening.push_back(make_event(OP_JACK, 1'b0, 4095));
        opening.push_back(make_event(OP_JACK, 1'b1, adc_for_mv(299)));
        opening.push_back(make_event(OP_JACK, 1'b1, adc_for_mv(300)));
        opening.push_back(make_event(OP_HOOK, 1'b1, 0));
        opening.push_back(make_event(OP_HOOK, 1'b1, 0));
        opening.push_back(make_event(OP_TIMER, 1'b1, adc_for_mv(299)));
        opening.push_back(make_event(OP_TIMER, 1'b1, adc_for_mv(300)));
        opening.push_back(make_event(OP_HOOK, 1'b1, 4095));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(20)));
        opening.push_back(make_event(OP_HOOK, 1'b1, 4095));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(59)));
        opening.push_back(make_event(OP_TIMER, 1'b1, 4095));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(60)));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(300)));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(110)));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(299)));
        opening.push_back(make_event(OP_HOOK, 1'b0, 0));
        opening.push_back(make_event(OP_HOOK, 1'b1, 0));
        opening.push_back(make_event(OP_JACK, 1'b1, 4095));
        opening.push_back(make_event(OP_HOOK, 1'b1, adc_for_mv(19)));
        opening.push_back(make_event(OP_JACK, 1'b0, 0));
        opening.push_back(make_event(OP_TIMER, 1'b1, 4095));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_event(opening[i]);

        for (p = 0; p < SettingCount; p++)
        begin
            wait_drained();
            cur_cfg = setting_for(p);
            load_setting(cur_cfg);
            settings_used++;
            idle_on = (p != SteadySetting);
            for (n = 0; n < EventsPerSetting; n++)
            begin
                if (p == HoldOffSetting && n == 10)
                    stall_requests++;
                if (p == PauseSetting && n == EventsPerSetting / 2)
                    wait_drained();
                send_event(random_event());
            end
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("Covered %0d event beats and %0d result beats across %0d register settings,",
                 events_sent, results_seen, settings_used);
        $display("with %0d key reports and %0d rejected button voltages among them.",
                 key_reports, rejections);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
